@@ src/affine_box_transform_2d_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the affine box transform core
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AFFINE_BOX_TRANSFORM_2D_CORE_ASSERT_SVH
`define AFFINE_BOX_TRANSFORM_2D_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ABT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ABT_ASSERT_IMPLY(lbl, ante, cons, msg)
`define ABT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ src/abt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_pkg
// Types, widths and codes shared by the affine box transform core.
// ----------------------------------------------------------------------------
package abt_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_W      = 2 * COORD_WIDTH;
    localparam int RND_W       = PROD_W + 1 - FRAC_BITS;
    localparam int SUM_W       = RND_W + 2;
    localparam int NUM_LANES   = 4;
    localparam int CFG_INDEX_W = 3;

    localparam logic [PROD_W:0] ROUND_HALF    = (PROD_W + 1)'(2 ** (FRAC_BITS - 1));
    localparam logic [PROD_W:0] ROUND_HALF_DN = ROUND_HALF - (PROD_W + 1)'(1);

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] COEF_ONE  = COORD_WIDTH'(2 ** FRAC_BITS);

    typedef enum logic [1:0] {
        OP_POINT  = 2'd0,
        OP_VECTOR = 2'd1,
        OP_BOX    = 2'd2
    } abt_op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COEF_XX  = 3'd0,
        CFG_COEF_XY  = 3'd1,
        CFG_COEF_YX  = 3'd2,
        CFG_COEF_YY  = 3'd3,
        CFG_OFFSET_X = 3'd4,
        CFG_OFFSET_Y = 3'd5
    } abt_cfg_idx_t;

    typedef struct packed {
        logic [1:0]                     op;
        logic signed [COORD_WIDTH-1:0]  in_min_x;
        logic signed [COORD_WIDTH-1:0]  in_min_y;
        logic signed [COORD_WIDTH-1:0]  in_max_x;
        logic signed [COORD_WIDTH-1:0]  in_max_y;
    } abt_in_word_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0]  out_min_x;
        logic signed [COORD_WIDTH-1:0]  out_min_y;
        logic signed [COORD_WIDTH-1:0]  out_max_x;
        logic signed [COORD_WIDTH-1:0]  out_max_y;
        logic                           saturated;
    } abt_out_word_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0]  xx;
        logic signed [COORD_WIDTH-1:0]  xy;
        logic signed [COORD_WIDTH-1:0]  yx;
        logic signed [COORD_WIDTH-1:0]  yy;
        logic signed [COORD_WIDTH-1:0]  off_x;
        logic signed [COORD_WIDTH-1:0]  off_y;
    } abt_coef_t;

    // one transformed corner
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0]  x;
        logic signed [COORD_WIDTH-1:0]  y;
        logic                           sat;
    } abt_corner_t;

    // per-stage load enables for a lane: product, round, sum
    typedef struct packed {
        logic en_mul;
        logic en_rnd;
        logic en_sum;
    } abt_lane_ctl_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0]  value;
        logic                           sat;
    } abt_clamp_t;

    function automatic abt_clamp_t clamp_sum(input logic signed [SUM_W-1:0] s);
        abt_clamp_t                         r;
        logic       [SUM_W-COORD_WIDTH:0]   upper;
        logic                               ovf;
        upper = s[SUM_W-1:COORD_WIDTH-1];
        ovf   = !((&upper) || !(|upper));
        r.sat = ovf;
        if (ovf)
        begin
            r.value = s[SUM_W-1] ? COORD_MIN : COORD_MAX;
        end
        else
        begin
            r.value = s[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

@@ src/affine_box_transform_2d_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_box_transform_2d_core
// 2D affine transform of a point, vector or axis-aligned box in Q16.16.
// Four corner lanes run in parallel; a merge stage takes min/max for boxes.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  src       src_valid / src_ready   src_data (abt_in_word_t)
//  dst       dst_valid / dst_ready   dst_data (abt_out_word_t)
//  cfg       cfg_we                  cfg_index, cfg_data
//
//  One word per cycle sustained while dst_ready stays high; four register
//  stages (multiply, round, sum/clamp, merge) lie between src and dst.
//  Each stage has its own valid bit and loads whenever it is empty or the
//  stage after it loads, so bubbles collapse; src stays ready while dst
//  stalls until all four stages hold a word. Reset clears valids and loads
//  the identity transform.
// ----------------------------------------------------------------------------
`include "affine_box_transform_2d_core_assert.svh"

module affine_box_transform_2d_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    src_valid,
    output logic                                    src_ready,
    input  abt_pkg::abt_in_word_t                   src_data,
    output logic                                    dst_valid,
    input  logic                                    dst_ready,
    output abt_pkg::abt_out_word_t                  dst_data,
    input  logic                                    cfg_we,
    input  logic [abt_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic signed [abt_pkg::COORD_WIDTH-1:0]  cfg_data
);
    import abt_pkg::*;

    localparam int STAGES = 4;

    abt_coef_t          coef_reg;
    logic [STAGES-1:0]  valid_reg;
    logic [STAGES-1:0]  en;
    logic [STAGES-2:0]  box_reg;
    logic               in_box, in_translate;
    abt_lane_ctl_t      lane_ctl;
    abt_corner_t        corners [NUM_LANES];
    logic               box_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.xx    <= COEF_ONE;
            coef_reg.xy    <= '0;
            coef_reg.yx    <= '0;
            coef_reg.yy    <= COEF_ONE;
            coef_reg.off_x <= '0;
            coef_reg.off_y <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COEF_XX:  coef_reg.xx    <= cfg_data;
                CFG_COEF_XY:  coef_reg.xy    <= cfg_data;
                CFG_COEF_YX:  coef_reg.yx    <= cfg_data;
                CFG_COEF_YY:  coef_reg.yy    <= cfg_data;
                CFG_OFFSET_X: coef_reg.off_x <= cfg_data;
                CFG_OFFSET_Y: coef_reg.off_y <= cfg_data;
                default:      ;
            endcase
        end
    end

    // stage enables: a stage loads when it is empty or its contents move on
    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || dst_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= src_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // op code 3 decodes by its high bit as a box
    assign in_box       = src_data.op[1];
    assign in_translate = (src_data.op != OP_VECTOR);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            box_reg[0] <= in_box;
        end
        for (int k = 1; k < STAGES - 1; k++)
        begin
            if (en[k])
            begin
                box_reg[k] <= box_reg[k-1];
            end
        end
    end

    assign lane_ctl.en_mul = en[0];
    assign lane_ctl.en_rnd = en[1];
    assign lane_ctl.en_sum = en[2];

    // lane i takes max x when bit 0 of i is set, max y when bit 1 is set
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        localparam bit USE_MAX_X = (i % 2) == 1;
        localparam bit USE_MAX_Y = ((i / 2) % 2) == 1;

        abt_lane u_lane (
            .clk       (clk),
            .ctl       (lane_ctl),
            .x         (USE_MAX_X ? src_data.in_max_x : src_data.in_min_x),
            .y         (USE_MAX_Y ? src_data.in_max_y : src_data.in_min_y),
            .translate (in_translate),
            .coef      (coef_reg),
            .result    (corners[i])
        );
    end

    abt_merge u_merge (
        .clk     (clk),
        .en      (en[STAGES-1]),
        .box     (box_reg[STAGES-2]),
        .corners (corners),
        .word    (dst_data),
        .box_out (box_out)
    );

    assign src_ready = en[0];
    assign dst_valid = valid_reg[STAGES-1];

    `ABT_ASSERT_NEXT(a_accept_enters, src_valid && src_ready, valid_reg[0],
        "accepted word did not enter the product stage")
    `ABT_ASSERT_IMPLY(a_ready_when_empty, !valid_reg[0], src_ready,
        "src not ready with an empty product stage")
    `ABT_ASSERT_IMPLY(a_min_le_max_x, dst_valid,
        dst_data.out_min_x <= dst_data.out_max_x, "result min x above max x")
    `ABT_ASSERT_IMPLY(a_min_le_max_y, dst_valid,
        dst_data.out_min_y <= dst_data.out_max_y, "result min y above max y")
    `ABT_ASSERT_IMPLY(a_point_equal, dst_valid && !box_out,
        dst_data.out_min_x == dst_data.out_max_x && dst_data.out_min_y == dst_data.out_max_y,
        "point or vector result with min and max apart")

endmodule

@@ src/abt_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_lane
// Transforms one corner: four products, Q16.16 rounding, sum with
// optional offset and saturation. Three register stages.
// ----------------------------------------------------------------------------
module abt_lane (
    input  logic                                    clk,
    input  abt_pkg::abt_lane_ctl_t                  ctl,
    input  logic signed [abt_pkg::COORD_WIDTH-1:0]  x,
    input  logic signed [abt_pkg::COORD_WIDTH-1:0]  y,
    input  logic                                    translate,
    input  abt_pkg::abt_coef_t                      coef,
    output abt_pkg::abt_corner_t                    result
);
    import abt_pkg::*;

    // round to nearest, ties away from zero
    function automatic logic signed [RND_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
        logic [PROD_W:0] ext;
        ext = {p[PROD_W-1], p} + (p[PROD_W-1] ? ROUND_HALF_DN : ROUND_HALF);
        return ext[PROD_W:FRAC_BITS];
    endfunction

    logic signed [PROD_W-1:0]  p_xx_reg, p_yx_reg, p_xy_reg, p_yy_reg;
    logic signed [RND_W-1:0]   r_xx_reg, r_yx_reg, r_xy_reg, r_yy_reg;
    logic                      trans_mul_reg, trans_rnd_reg;
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    abt_clamp_t                cl_x, cl_y;
    abt_corner_t               result_reg, result_next;

    always_ff @(posedge clk)
    begin
        if (ctl.en_mul)
        begin
            p_xx_reg      <= x * coef.xx;
            p_yx_reg      <= y * coef.yx;
            p_xy_reg      <= x * coef.xy;
            p_yy_reg      <= y * coef.yy;
            trans_mul_reg <= translate;
        end
        if (ctl.en_rnd)
        begin
            r_xx_reg      <= round_q(p_xx_reg);
            r_yx_reg      <= round_q(p_yx_reg);
            r_xy_reg      <= round_q(p_xy_reg);
            r_yy_reg      <= round_q(p_yy_reg);
            trans_rnd_reg <= trans_mul_reg;
        end
        if (ctl.en_sum)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        sum_x = SUM_W'(r_xx_reg) + SUM_W'(r_yx_reg)
              + (trans_rnd_reg ? SUM_W'(coef.off_x) : SUM_W'(0));
        sum_y = SUM_W'(r_xy_reg) + SUM_W'(r_yy_reg)
              + (trans_rnd_reg ? SUM_W'(coef.off_y) : SUM_W'(0));
        cl_x  = clamp_sum(sum_x);
        cl_y  = clamp_sum(sum_y);
        result_next.x   = cl_x.value;
        result_next.y   = cl_y.value;
        result_next.sat = cl_x.sat || cl_y.sat;
    end

    assign result = result_reg;

endmodule

@@ src/abt_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_merge
// Combines the corner lanes into the result word: per-axis min and max for
// boxes, lane 0 alone for points and vectors. Holds the output register.
// ----------------------------------------------------------------------------
module abt_merge (
    input  logic                    clk,
    input  logic                    en,
    input  logic                    box,
    input  abt_pkg::abt_corner_t    corners [abt_pkg::NUM_LANES],
    output abt_pkg::abt_out_word_t  word,
    output logic                    box_out
);
    import abt_pkg::*;

    logic signed [COORD_WIDTH-1:0]  lo_x, lo_y, hi_x, hi_y;
    logic                           sat_any;
    abt_out_word_t                  word_reg, word_next;
    logic                           box_reg;

    always_comb
    begin
        lo_x    = corners[0].x;
        hi_x    = corners[0].x;
        lo_y    = corners[0].y;
        hi_y    = corners[0].y;
        sat_any = corners[0].sat;
        for (int i = 1; i < NUM_LANES; i++)
        begin
            if (corners[i].x < lo_x) lo_x = corners[i].x;
            if (corners[i].x > hi_x) hi_x = corners[i].x;
            if (corners[i].y < lo_y) lo_y = corners[i].y;
            if (corners[i].y > hi_y) hi_y = corners[i].y;
            sat_any = sat_any | corners[i].sat;
        end
        if (box)
        begin
            word_next.out_min_x = lo_x;
            word_next.out_min_y = lo_y;
            word_next.out_max_x = hi_x;
            word_next.out_max_y = hi_y;
            word_next.saturated = sat_any;
        end
        else
        begin
            word_next.out_min_x = corners[0].x;
            word_next.out_min_y = corners[0].y;
            word_next.out_max_x = corners[0].x;
            word_next.out_max_y = corners[0].y;
            word_next.saturated = corners[0].sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
            box_reg  <= box;
        end
    end

    assign word    = word_reg;
    assign box_out = box_reg;

endmodule

@@ verif/affine_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_result_checker
// Watches the config port and both channels of the affine box transform core.
// Keeps a shadow copy of the six coefficient registers, works out the
// transformed point, vector or box for every accepted input word, and matches
// each accepted output word against the oldest pending prediction.
// ----------------------------------------------------------------------------
module affine_result_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    src_valid,
    input  logic                                    src_ready,
    input  abt_pkg::abt_in_word_t                   src_data,
    input  logic                                    dst_valid,
    input  logic                                    dst_ready,
    input  abt_pkg::abt_out_word_t                  dst_data,
    input  logic                                    cfg_we,
    input  logic [abt_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic signed [abt_pkg::COORD_WIDTH-1:0]  cfg_data,
    output int                                      mismatches,
    output int                                      outstanding
);
    import abt_pkg::*;

    abt_coef_t      shadow;
    abt_out_word_t  transformed_q[$];
    int             fault_count = 0;
    int             waiting = 0;

    assign mismatches  = fault_count;
    assign outstanding = waiting;

    // exact product, then round half away from zero to Q16.16
    function automatic longint rounded_product(input logic signed [COORD_WIDTH-1:0] a,
                                               input logic signed [COORD_WIDTH-1:0] b);
        longint prod;
        longint mag;
        prod = longint'(a) * longint'(b);
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + 64'sd32768) >>> FRAC_BITS;
        return (prod < 0) ? -mag : mag;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] fit_coord(input longint s,
                                                                inout bit sat);
        logic signed [COORD_WIDTH-1:0] hi_lim;
        logic signed [COORD_WIDTH-1:0] lo_lim;
        hi_lim = COORD_MAX;
        lo_lim = COORD_MIN;
        if (s > longint'(hi_lim))
        begin
            sat = 1'b1;
            return hi_lim;
        end
        if (s < longint'(lo_lim))
        begin
            sat = 1'b1;
            return lo_lim;
        end
        return s[COORD_WIDTH-1:0];
    endfunction

    function automatic void map_point(input logic signed [COORD_WIDTH-1:0] x,
                                      input logic signed [COORD_WIDTH-1:0] y,
                                      input bit shift_on,
                                      output logic signed [COORD_WIDTH-1:0] ox,
                                      output logic signed [COORD_WIDTH-1:0] oy,
                                      inout bit sat);
        logic signed [COORD_WIDTH-1:0] kxx, kxy, kyx, kyy, ofs_x, ofs_y;
        longint                        sx, sy;
        kxx   = shadow.xx;
        kxy   = shadow.xy;
        kyx   = shadow.yx;
        kyy   = shadow.yy;
        ofs_x = shadow.off_x;
        ofs_y = shadow.off_y;
        sx = rounded_product(x, kxx) + rounded_product(y, kyx);
        sy = rounded_product(x, kxy) + rounded_product(y, kyy);
        if (shift_on)
        begin
            sx = sx + longint'(ofs_x);
            sy = sy + longint'(ofs_y);
        end
        ox = fit_coord(sx, sat);
        oy = fit_coord(sy, sat);
    endfunction

    function automatic abt_out_word_t transform_word(input abt_in_word_t w);
        logic signed [COORD_WIDTH-1:0] x0, y0, x1, y1;
        logic signed [COORD_WIDTH-1:0] cx[4];
        logic signed [COORD_WIDTH-1:0] cy[4];
        logic signed [COORD_WIDTH-1:0] lx, ly, hx, hy;
        bit                            sat;
        int                            k;
        abt_out_word_t                 r;
        x0  = w.in_min_x;
        y0  = w.in_min_y;
        x1  = w.in_max_x;
        y1  = w.in_max_y;
        sat = 1'b0;
        // high op bit selects box, so the unused code acts as a box too
        if (w.op[1])
        begin
            map_point(x0, y0, 1'b1, cx[0], cy[0], sat);
            map_point(x1, y0, 1'b1, cx[1], cy[1], sat);
            map_point(x0, y1, 1'b1, cx[2], cy[2], sat);
            map_point(x1, y1, 1'b1, cx[3], cy[3], sat);
            lx = cx[0];
            hx = cx[0];
            ly = cy[0];
            hy = cy[0];
            for (k = 1; k < 4; k++)
            begin
                if (cx[k] < lx) lx = cx[k];
                if (cx[k] > hx) hx = cx[k];
                if (cy[k] < ly) ly = cy[k];
                if (cy[k] > hy) hy = cy[k];
            end
        end
        else
        begin
            map_point(x0, y0, w.op == OP_POINT, lx, ly, sat);
            hx = lx;
            hy = ly;
        end
        r.out_min_x = lx;
        r.out_min_y = ly;
        r.out_max_x = hx;
        r.out_max_y = hy;
        r.saturated = sat;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [COORD_WIDTH-1:0] want,
                               input logic [COORD_WIDTH-1:0] got);
        if (want !== got)
        begin
            fault_count++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        abt_out_word_t want;
        if (!rst_n)
        begin
            shadow.xx    = COEF_ONE;
            shadow.xy    = '0;
            shadow.yx    = '0;
            shadow.yy    = COEF_ONE;
            shadow.off_x = '0;
            shadow.off_y = '0;
            transformed_q.delete();
            waiting <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COEF_XX:  shadow.xx    = cfg_data;
                    CFG_COEF_XY:  shadow.xy    = cfg_data;
                    CFG_COEF_YX:  shadow.yx    = cfg_data;
                    CFG_COEF_YY:  shadow.yy    = cfg_data;
                    CFG_OFFSET_X: shadow.off_x = cfg_data;
                    CFG_OFFSET_Y: shadow.off_y = cfg_data;
                    default: ;
                endcase
            end
            // retire the output word before queuing the input word
            if (dst_valid && dst_ready)
            begin
                if (transformed_q.size() == 0)
                begin
                    fault_count++;
                    $display("%0t: output word expected none actual %h", $time, dst_data);
                end
                else
                begin
                    want = transformed_q.pop_front();
                    check_field("out_min_x", want.out_min_x, dst_data.out_min_x);
                    check_field("out_min_y", want.out_min_y, dst_data.out_min_y);
                    check_field("out_max_x", want.out_max_x, dst_data.out_max_x);
                    check_field("out_max_y", want.out_max_y, dst_data.out_max_y);
                    check_field("saturated", COORD_WIDTH'(want.saturated),
                                COORD_WIDTH'(dst_data.saturated));
                end
            end
            if (src_valid && src_ready)
                transformed_q.push_back(transform_word(src_data));
            waiting <= transformed_q.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the affine box transform core: directed corner cases under
// identity, rounding-tie and extreme coefficient sets, then random points,
// vectors and boxes across several coefficient sets and idling mixes, with
// one long output hold-off. The checker module does all result comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import abt_pkg::*;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int LONG_HOLD       = 300;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int BURST_ITEMS     = 40;

    localparam logic [1:0]             OP_BOX_ALT       = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    localparam logic signed [COORD_WIDTH-1:0] ONE_Q  = COEF_ONE;
    localparam logic signed [COORD_WIDTH-1:0] HALF_Q = ONE_Q >>> 1;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           src_valid = 1'b0;
    logic                           src_ready;
    abt_in_word_t                   src_data = '0;
    logic                           dst_valid;
    logic                           dst_ready = 1'b0;
    abt_out_word_t                  dst_data;
    logic                           cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]         cfg_index = '0;
    logic signed [COORD_WIDTH-1:0]  cfg_data = '0;

    int   mismatches;
    int   outstanding;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_left = 0;
    int   cycle_count = 0;
    logic hold_kick = 1'b0;

    always #2 clk = ~clk;

    affine_box_transform_2d_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    affine_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_ready   (src_ready),
        .src_data    (src_data),
        .dst_valid   (dst_valid),
        .dst_ready   (dst_ready),
        .dst_data    (dst_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // output side: random stalls, or a long hold-off when kicked
    always @(posedge clk)
    begin
        if (hold_kick)
            hold_left = LONG_HOLD;
        if (hold_left > 0)
        begin
            hold_left--;
            dst_ready <= 1'b0;
        end
        else
        begin
            dst_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[affine_box_transform_2d_core] ERROR");
            $finish;
        end
    end

    task automatic send_word(input abt_in_word_t w);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= w;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
    endtask

    task automatic issue(input logic [1:0] op,
                         input logic signed [COORD_WIDTH-1:0] ax,
                         input logic signed [COORD_WIDTH-1:0] ay,
                         input logic signed [COORD_WIDTH-1:0] bx,
                         input logic signed [COORD_WIDTH-1:0] by);
        abt_in_word_t w;
        w.op       = op;
        w.in_min_x = ax;
        w.in_min_y = ay;
        w.in_max_x = bx;
        w.in_max_y = by;
        send_word(w);
    endtask

    // stop offering words and wait until every result is back
    task automatic drain();
        src_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic signed [COORD_WIDTH-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    // only called with the core idle; unmapped indexes must be ignored
    task automatic load_coefs(input abt_coef_t c);
        put_reg(CFG_COEF_XX,  c.xx);
        put_reg(CFG_IDX_SPARE_LO, $urandom);
        put_reg(CFG_COEF_XY,  c.xy);
        put_reg(CFG_COEF_YX,  c.yx);
        put_reg(CFG_COEF_YY,  c.yy);
        put_reg(CFG_OFFSET_X, c.off_x);
        put_reg(CFG_OFFSET_Y, c.off_y);
        put_reg(CFG_IDX_SPARE_HI, $urandom);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return int'($urandom_range(0, 2097152)) - 1048576;
            7:          return COORD_MAX;
            8:          return COORD_MIN;
            default:    return int'($urandom_range(0, 4)) - 2;
        endcase
    endfunction

    // mostly within +/-4.0 so that saturation stays the exception
    function automatic logic signed [COORD_WIDTH-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
            default: return int'($urandom_range(0, 524288)) - 262144;
        endcase
    endfunction

    function automatic abt_coef_t rand_coefs();
        abt_coef_t c;
        c.xx    = rand_weight();
        c.xy    = rand_weight();
        c.yx    = rand_weight();
        c.yy    = rand_weight();
        c.off_x = rand_coord();
        c.off_y = rand_coord();
        return c;
    endfunction

    function automatic abt_in_word_t rand_item();
        abt_in_word_t                  w;
        int                            pick;
        longint                        far;
        logic signed [COORD_WIDTH-1:0] lo;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            w.op = OP_POINT;
        else if (pick < 55)
            w.op = OP_VECTOR;
        else if (pick < 95)
            w.op = OP_BOX;
        else
            w.op = OP_BOX_ALT;
        w.in_min_x = rand_coord();
        w.in_min_y = rand_coord();
        w.in_max_x = rand_coord();
        w.in_max_y = rand_coord();
        // most boxes well ordered, the rest arbitrary or inverted
        if (w.op[1] && $urandom_range(0, 99) < 60)
        begin
            lo  = w.in_min_x;
            far = longint'(lo) + longint'($urandom_range(0, 4194304));
            w.in_max_x = (far > longint'(COORD_MAX)) ? COORD_MAX : far[COORD_WIDTH-1:0];
            lo  = w.in_min_y;
            far = longint'(lo) + longint'($urandom_range(0, 4194304));
            w.in_max_y = (far > longint'(COORD_MAX)) ? COORD_MAX : far[COORD_WIDTH-1:0];
        end
        return w;
    endfunction

    initial
    begin
        int ph;
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity after reset
        issue(OP_POINT,  '0, '0, $urandom, $urandom);
        issue(OP_POINT,  COORD_MAX, COORD_MIN, $urandom, $urandom);
        issue(OP_VECTOR, COORD_MIN, COORD_MAX, $urandom, $urandom);
        issue(OP_BOX,    -ONE_Q, -2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q);
        issue(OP_BOX,    5 * ONE_Q, 5 * ONE_Q, -5 * ONE_Q, -5 * ONE_Q);
        issue(OP_BOX_ALT, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q);
        drain();

        // half-weights make exact ties in the rounding
        load_coefs('{HALF_Q, -HALF_Q, 3 * HALF_Q, -ONE_Q, ONE_Q, COORD_MAX});
        issue(OP_POINT,  32'sd1, '0, '0, '0);
        issue(OP_POINT,  -32'sd1, 32'sd1, '0, '0);
        issue(OP_POINT,  32'sd3, -32'sd3, '0, '0);
        issue(OP_VECTOR, 32'sd1, 32'sd1, '0, '0);
        issue(OP_BOX,    COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        issue(OP_POINT,  COORD_MAX, COORD_MAX, '0, '0);
        drain();

        load_coefs('{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX});
        issue(OP_POINT,  COORD_MAX, COORD_MAX, '0, '0);
        issue(OP_VECTOR, COORD_MIN, COORD_MIN, '0, '0);
        issue(OP_BOX,    -ONE_Q, -ONE_Q, ONE_Q, ONE_Q);
        drain();

        load_coefs('{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN});
        issue(OP_POINT,  COORD_MIN, COORD_MIN, '0, '0);
        issue(OP_VECTOR, COORD_MAX, COORD_MIN, '0, '0);
        issue(OP_BOX,    '0, '0, '0, '0);
        issue(OP_POINT,  '0, '0, '0, '0);
        drain();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            load_coefs(rand_coefs());
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_word(rand_item());
            drain();

            // back-pressure: output held off while words keep coming
            if (ph == RANDOM_PHASES / 2)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                hold_kick <= 1'b1;
                @(posedge clk);
                hold_kick <= 1'b0;
                for (n = 0; n < BURST_ITEMS; n++)
                    send_word(rand_item());
                drain();
            end
        end

        if (mismatches == 0 && outstanding == 0)
            $display("[affine_box_transform_2d_core] OK");
        else
            $display("[affine_box_transform_2d_core] ERROR");
        $finish;
    end

endmodule
